/* src/ppe_pkg.sv */
// Shared types, constants and helpers of the palette pixel expander.
package ppe_pkg;

  localparam int unsigned PIXEL_W             = 32;
  localparam int unsigned CHAN_W              = 8;
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned OUT_DEPTH           = 3;
  localparam int unsigned OUT_CNT_W           = $clog2(OUT_DEPTH + 1);
  localparam int unsigned SHIFT_W             = $clog2(PIXEL_W);
  localparam int unsigned CWIDTH_W            = $clog2(CHAN_W + 1);
  localparam int unsigned CFG_IDX_W           = 3;

  localparam logic [CWIDTH_W-1:0] WIDTH_CAP  = CWIDTH_W'(CHAN_W);
  localparam logic [CHAN_W-1:0]   ALPHA_FULL = 8'hFF;
  localparam logic [PIXEL_W-1:0]  KEY_16BIT  = 32'h0000_7C1F;
  localparam logic [PIXEL_W-1:0]  KEY_32BIT  = 32'h0000_0000;
  localparam logic [PIXEL_W-1:0]  LOW16_MASK = 32'h0000_FFFF;

  localparam logic [PIXEL_W-1:0] RED_MASK_RST   = 32'h0000_F800;
  localparam logic [PIXEL_W-1:0] GREEN_MASK_RST = 32'h0000_07E0;
  localparam logic [PIXEL_W-1:0] BLUE_MASK_RST  = 32'h0000_001F;
  localparam logic [PIXEL_W-1:0] ALPHA_MASK_RST = 32'h0000_0000;

  typedef enum logic [1:0] {
    DEPTH_8      = 2'd0,
    DEPTH_16     = 2'd1,
    DEPTH_32     = 2'd2,
    DEPTH_32_ALT = 2'd3
  } depth_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MASK   = 3'd0,
    REG_GREEN_MASK = 3'd1,
    REG_BLUE_MASK  = 3'd2,
    REG_ALPHA_MASK = 3'd3,
    REG_DEPTH      = 3'd4,
    REG_TRANSP     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CWIDTH_W-1:0] width;
    logic [SHIFT_W-1:0]  shift;
  } chan_fmt_t;

  typedef struct packed {
    chan_fmt_t red;
    chan_fmt_t green;
    chan_fmt_t blue;
    chan_fmt_t alpha;
  } pix_fmt_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] red;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] blue;
    logic [PIXEL_W-1:0] alpha;
  } mask_set_t;

  function automatic logic [PIXEL_W-1:0] place_channel(input logic [CHAN_W-1:0] c,
                                                       input chan_fmt_t f);
    logic [CHAN_W-1:0] kept;
    kept = c >> (WIDTH_CAP - f.width);
    if (f.width == '0) begin
      return '0;
    end
    return PIXEL_W'(kept) << f.shift;
  endfunction

endpackage

/* src/palette_pixel_expander.sv */
// Top level of the palette pixel expander: registers, handshake and stage wiring.
//
// Takes one item per cycle when sustained. A palette write (tuser 0) stores its
// converted entry in the palette memory on acceptance, unless the depth is 8-bit
// or its index is out of range, and gives no result; a pixel item (tuser 1) reads
// the memory's single read port and its result is registered in the lookup stage
// and then in a three-entry result queue before it reaches the output stream.
// s_axis_tready is also low while three results wait in the lookup stage and the
// queue together, so a stalled output holds the input. The channel shifts and
// widths are found by a mask analyser that scans the four masks one bit per
// cycle: while it scans, after reset and after every write to a mask register,
// s_axis_tready is low. The palette reads as zero after reset with no clearing pass.
module palette_pixel_expander #(
  parameter int unsigned PALETTE_ENTRIES = ppe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // color_index [7:0], red_in [15:8], green_in [23:16], blue_in [31:24]
  input  logic [31:0]                       s_axis_tdata,
  // func [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_out [31:0]
  output logic [ppe_pkg::PIXEL_W-1:0]       m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppe_pkg::PIXEL_W-1:0]       cfg_data
);
  import ppe_pkg::*;

  localparam int unsigned PendW = $clog2(OUT_DEPTH + 2);

  logic [PIXEL_W-1:0] red_mask;
  logic [PIXEL_W-1:0] green_mask;
  logic [PIXEL_W-1:0] blue_mask;
  logic [PIXEL_W-1:0] alpha_mask;
  depth_t             pixel_depth;
  logic               transparent_enable;

  mask_set_t          masks;
  pix_fmt_t           fmt;
  logic               scan_start;
  logic               scan_busy;
  logic               accept;
  logic               res_valid;
  logic [PIXEL_W-1:0] res_data;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [PendW-1:0]   pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_mask           <= RED_MASK_RST;
      green_mask         <= GREEN_MASK_RST;
      blue_mask          <= BLUE_MASK_RST;
      alpha_mask         <= ALPHA_MASK_RST;
      pixel_depth        <= DEPTH_16;
      transparent_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RED_MASK:   red_mask           <= cfg_data;
        REG_GREEN_MASK: green_mask         <= cfg_data;
        REG_BLUE_MASK:  blue_mask          <= cfg_data;
        REG_ALPHA_MASK: alpha_mask         <= cfg_data;
        REG_DEPTH:      pixel_depth        <= depth_t'(cfg_data[1:0]);
        REG_TRANSP:     transparent_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK, REG_ALPHA_MASK: scan_start = cfg_we;
      default: scan_start = 1'b0;
    endcase
  end

  assign masks.red   = red_mask;
  assign masks.green = green_mask;
  assign masks.blue  = blue_mask;
  assign masks.alpha = alpha_mask;

  ppe_mask_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .masks (masks),
    .fmt   (fmt),
    .busy  (scan_busy)
  );

  assign pending       = PendW'(fifo_count) + PendW'(res_valid);
  assign s_axis_tready = !scan_busy && (pending < PendW'(OUT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  ppe_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .func               (func_t'(s_axis_tuser)),
    .color_index        (s_axis_tdata[7:0]),
    .red_in             (s_axis_tdata[15:8]),
    .green_in           (s_axis_tdata[23:16]),
    .blue_in            (s_axis_tdata[31:24]),
    .fmt                (fmt),
    .pixel_depth        (pixel_depth),
    .transparent_enable (transparent_enable),
    .res_valid          (res_valid),
    .res_data           (res_data)
  );

  ppe_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .tdata     (m_axis_tdata),
    .count     (fifo_count)
  );
endmodule

/* src/ppe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppe_ram #(
  parameter int unsigned WIDTH = ppe_pkg::PIXEL_W,
  parameter int unsigned DEPTH = ppe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/ppe_mask_scan.sv */
// Bit-serial analyser giving shift and capped width of each channel mask.
module ppe_mask_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ppe_pkg::mask_set_t  masks,
  output ppe_pkg::pix_fmt_t   fmt,
  output logic                busy
);
  import ppe_pkg::*;

  localparam int unsigned LANES = 4;
  localparam logic [SHIFT_W-1:0] LastPos = SHIFT_W'(PIXEL_W - 1);

  logic [PIXEL_W-1:0] lane_mask [LANES];
  chan_fmt_t          lane      [LANES];
  chan_fmt_t          lane_next [LANES];
  logic [LANES-1:0]   found;
  logic [LANES-1:0]   found_next;
  logic [SHIFT_W-1:0] bit_pos;

  assign lane_mask[0] = masks.red;
  assign lane_mask[1] = masks.green;
  assign lane_mask[2] = masks.blue;
  assign lane_mask[3] = masks.alpha;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_next[i]  = lane[i];
      found_next[i] = found[i];
      if (lane_mask[i][bit_pos]) begin
        if (!found[i]) begin
          lane_next[i].shift = bit_pos;
          found_next[i]      = 1'b1;
        end
        if (lane[i].width != WIDTH_CAP) begin
          lane_next[i].width = lane[i].width + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy    <= 1'b1;
      bit_pos <= '0;
      found   <= '0;
      for (int i = 0; i < LANES; i++) begin
        lane[i] <= '0;
      end
    end else if (busy) begin
      bit_pos <= bit_pos + 1'b1;
      found   <= found_next;
      for (int i = 0; i < LANES; i++) begin
        lane[i] <= lane_next[i];
      end
      if (bit_pos == LastPos) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    fmt.red   = lane[0];
    fmt.green = lane[1];
    fmt.blue  = lane[2];
    fmt.alpha = lane[3];
  end

  a_width_cap: assert property (@(posedge clk) disable iff (rst)
    fmt.red.width <= WIDTH_CAP && fmt.green.width <= WIDTH_CAP &&
    fmt.blue.width <= WIDTH_CAP && fmt.alpha.width <= WIDTH_CAP)
    else $error("channel width above cap");

  a_fmt_hold: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(fmt))
    else $error("format changed outside a scan");

  a_width_needs_found: assert property (@(posedge clk) disable iff (rst)
    (!found[0] |-> fmt.red.width == '0) and (!found[3] |-> fmt.alpha.width == '0))
    else $error("width counted before first mask bit");
endmodule

/* src/ppe_palette.sv */
// Palette store: entry build on write, lookup and result select on pixel items.
module ppe_palette #(
  parameter int unsigned ENTRIES = ppe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  ppe_pkg::func_t               func,
  input  logic [ppe_pkg::CHAN_W-1:0]   color_index,
  input  logic [ppe_pkg::CHAN_W-1:0]   red_in,
  input  logic [ppe_pkg::CHAN_W-1:0]   green_in,
  input  logic [ppe_pkg::CHAN_W-1:0]   blue_in,
  input  ppe_pkg::pix_fmt_t            fmt,
  input  ppe_pkg::depth_t              pixel_depth,
  input  logic                         transparent_enable,
  output logic                         res_valid,
  output logic [ppe_pkg::PIXEL_W-1:0]  res_data
);
  import ppe_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);

  logic               in_range;
  logic               is_key;
  logic [PIXEL_W-1:0] colour;
  logic [PIXEL_W-1:0] entry;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      addr;
  logic [PIXEL_W-1:0] rd_data;
  logic [ENTRIES-1:0] filled;
  logic [PIXEL_W-1:0] const_value;

  logic               s1_use_mem;
  logic               s1_narrow;
  logic [AW-1:0]      s1_addr;
  logic [PIXEL_W-1:0] s1_const;
  logic [PIXEL_W-1:0] raw;

  assign in_range = {1'b0, color_index} < (CHAN_W + 1)'(ENTRIES);
  assign addr     = color_index[AW-1:0];
  assign is_key   = transparent_enable && (color_index == '0);

  always_comb begin
    colour = place_channel(red_in, fmt.red) | place_channel(green_in, fmt.green) |
             place_channel(blue_in, fmt.blue);
    if (pixel_depth == DEPTH_16) begin
      entry = colour & LOW16_MASK;
    end else if (fmt.alpha.width != '0) begin
      entry = colour | place_channel(ALPHA_FULL, fmt.alpha);
    end else begin
      entry = colour | PIXEL_W'(ALPHA_FULL);
    end
  end

  assign wr_en = accept && (func == FUNC_WRITE) && (pixel_depth != DEPTH_8) && in_range;
  assign rd_en = accept && (func == FUNC_PIXEL);

  always_comb begin
    if (pixel_depth == DEPTH_8) begin
      const_value = PIXEL_W'(color_index);
    end else if (is_key) begin
      const_value = (pixel_depth == DEPTH_16) ? KEY_16BIT : KEY_32BIT;
    end else begin
      const_value = '0;
    end
  end

  ppe_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (entry),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_use_mem <= (pixel_depth != DEPTH_8) && !is_key && in_range;
      s1_narrow  <= (pixel_depth == DEPTH_16);
      s1_addr    <= addr;
      s1_const   <= const_value;
    end
  end

  assign raw      = s1_use_mem ? (filled[s1_addr] ? rd_data : '0) : s1_const;
  assign res_data = s1_narrow ? (raw & LOW16_MASK) : raw;

  a_result_follows_pixel: assert property (@(posedge clk) disable iff (rst)
    !rst |=> res_valid == $past(rd_en))
    else $error("result not one cycle after pixel item");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !res_valid)
    else $error("palette write gave a result");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && s1_narrow |-> res_data[PIXEL_W-1:16] == '0)
    else $error("16-bit result has upper bits set");
endmodule

/* src/ppe_out_fifo.sv */
// Small result queue that parts the lookup stage from the output stream.
module ppe_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [ppe_pkg::PIXEL_W-1:0]    push_data,
  output logic                           tvalid,
  input  logic                           tready,
  output logic [ppe_pkg::PIXEL_W-1:0]    tdata,
  output logic [ppe_pkg::OUT_CNT_W-1:0]  count
);
  import ppe_pkg::*;

  localparam int unsigned PtrW = $clog2(OUT_DEPTH);

  logic [PIXEL_W-1:0] slot [OUT_DEPTH];
  logic [PtrW-1:0]    head;
  logic [PtrW-1:0]    tail;
  logic               pop;

  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tvalid = (count != '0);
  assign tdata  = slot[head];
  assign pop    = tvalid && tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= step_ptr(tail);
      end
      if (pop) begin
        head <= step_ptr(head);
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[tail] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == OUT_CNT_W'(OUT_DEPTH)))
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == OUT_CNT_W'($past(count) + OUT_CNT_W'($past(push)) -
                                 OUT_CNT_W'($past(pop))))
    else $error("queue count lost track");
endmodule

/* tb/palette_pixel_expander_tb.sv */
// Self-checking stream testbench for the palette pixel expander.
`timescale 1ns / 1ps

module palette_pixel_expander_tb;
  import ppe_pkg::*;

  typedef struct {
    func_t       func;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          drain;
  } palette_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PIXEL_W-1:0]   m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIXEL_W-1:0]   cfg_data = '0;

  palette_req_t         pending_items[$];
  palette_req_t         in_flight;
  logic [PIXEL_W-1:0]   pixels_due[$];
  int                   items_queued = 0;
  int                   items_accepted = 0;
  int                   errors = 0;
  int                   send_idle_pct = 27;
  int                   recv_idle_pct = 27;

  logic [PIXEL_W-1:0]   fmt_red = RED_MASK_RST;
  logic [PIXEL_W-1:0]   fmt_green = GREEN_MASK_RST;
  logic [PIXEL_W-1:0]   fmt_blue = BLUE_MASK_RST;
  logic [PIXEL_W-1:0]   fmt_alpha = ALPHA_MASK_RST;
  depth_t               cur_depth = DEPTH_16;
  logic                 key_enable = 1'b0;
  logic [PIXEL_W-1:0]   palette_copy[256];

  palette_pixel_expander u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [3:0] chan_width(input logic [PIXEL_W-1:0] mask);
    int n;
    n = 0;
    for (int i = 0; i < PIXEL_W; i++) begin
      n += mask[i];
    end
    return (n > 8) ? 4'd8 : 4'(n);
  endfunction

  function automatic logic [4:0] chan_shift(input logic [PIXEL_W-1:0] mask);
    for (int i = 0; i < PIXEL_W; i++) begin
      if (mask[i]) begin
        return 5'(i);
      end
    end
    return 5'd0;
  endfunction

  function automatic logic [PIXEL_W-1:0] place_bits(input logic [7:0] c,
                                                    input logic [PIXEL_W-1:0] mask);
    logic [3:0] w;
    logic [7:0] kept;
    w = chan_width(mask);
    if (w == 4'd0) begin
      return '0;
    end
    kept = c >> (4'd8 - w);
    return PIXEL_W'(kept) << chan_shift(mask);
  endfunction

  function automatic logic [PIXEL_W-1:0] encode_entry(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
    logic [PIXEL_W-1:0] e;
    e = place_bits(r, fmt_red) | place_bits(g, fmt_green) | place_bits(b, fmt_blue);
    if (cur_depth == DEPTH_16) begin
      e &= LOW16_MASK;
    end else if (chan_width(fmt_alpha) != 4'd0) begin
      e |= place_bits(ALPHA_FULL, fmt_alpha);
    end else begin
      e |= PIXEL_W'(ALPHA_FULL);
    end
    return e;
  endfunction

  function automatic logic [PIXEL_W-1:0] expand_pixel(input logic [7:0] idx);
    if (cur_depth == DEPTH_8) begin
      return PIXEL_W'(idx);
    end
    if (key_enable && idx == 8'd0) begin
      return (cur_depth == DEPTH_16) ? KEY_16BIT : KEY_32BIT;
    end
    if (cur_depth == DEPTH_16) begin
      return palette_copy[idx] & LOW16_MASK;
    end
    return palette_copy[idx];
  endfunction

  task automatic apply_item(input palette_req_t it);
    if (it.func == FUNC_PIXEL) begin
      pixels_due.push_back(expand_pixel(it.idx));
    end else if (cur_depth != DEPTH_8) begin
      palette_copy[it.idx] = encode_entry(it.red, it.green, it.blue);
    end
  endtask

  task automatic note_error(input string what, input logic [PIXEL_W-1:0] want,
                            input logic [PIXEL_W-1:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s expected %08h actual %08h", $realtime, what, want, got);
    end
  endtask

  task automatic queue_item(input func_t func, input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input bit drain);
    palette_req_t it;
    it.func = func;
    it.idx = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.drain = drain;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random_item();
    logic [7:0] idx;
    idx = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    queue_item(func_t'($urandom_range(1)), idx, 8'($urandom), 8'($urandom), 8'($urandom),
               $urandom_range(59) == 0);
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || pixels_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [PIXEL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    case (which)
      REG_RED_MASK:   fmt_red = val;
      REG_GREEN_MASK: fmt_green = val;
      REG_BLUE_MASK:  fmt_blue = val;
      REG_ALPHA_MASK: fmt_alpha = val;
      REG_DEPTH:      cur_depth = depth_t'(val[1:0]);
      REG_TRANSP:     key_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] g,
                            input logic [PIXEL_W-1:0] b, input logic [PIXEL_W-1:0] a,
                            input depth_t depth, input logic transp);
    wait_idle();
    write_reg(REG_RED_MASK, r);
    write_reg(REG_GREEN_MASK, g);
    write_reg(REG_BLUE_MASK, b);
    write_reg(REG_ALPHA_MASK, a);
    write_reg(REG_DEPTH, PIXEL_W'(depth));
    write_reg(REG_TRANSP, PIXEL_W'(transp));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PIXEL_W-1:0] pick_mask();
    logic [63:0] run;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return PIXEL_W'($urandom);
      3: return PIXEL_W'(1) << $urandom_range(31);
      default: begin
        run = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(31);
        return run[PIXEL_W-1:0];
      end
    endcase
  endfunction

  always @(posedge clk) begin : drive_items
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(in_flight);
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_items[0].drain && pixels_due.size() != 0)) begin
          in_flight = pending_items.pop_front();
          s_axis_tdata <= {in_flight.blue, in_flight.green, in_flight.red, in_flight.idx};
          s_axis_tuser <= in_flight.func;
          next_valid = 1'b1;
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    logic [PIXEL_W-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          note_error("unexpected pixel", '0, m_axis_tdata);
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata !== want) begin
            note_error("pixel_out", want, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      palette_copy[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset format: 16-bit 565, no key
    queue_item(FUNC_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_item(FUNC_WRITE, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_WRITE, 8'd1, 8'h80, 8'h40, 8'hFF, 1'b0);
    queue_item(FUNC_WRITE, 8'd2, 8'hFF, 8'h00, 8'h55, 1'b0);
    queue_item(FUNC_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_PIXEL, 8'd1, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_item(FUNC_PIXEL, 8'd2, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'h7C00, 32'h03E0, 32'h001F, 32'h0, DEPTH_16, 1'b1);
    queue_item(FUNC_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_WRITE, 8'd3, 8'hAA, 8'h55, 8'hCC, 1'b0);
    queue_item(FUNC_PIXEL, 8'd3, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, DEPTH_32, 1'b1);
    queue_item(FUNC_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_WRITE, 8'd4, 8'h12, 8'h34, 8'h56, 1'b0);
    queue_item(FUNC_PIXEL, 8'd4, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_PIXEL, 8'd3, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0, DEPTH_32, 1'b0);
    queue_item(FUNC_WRITE, 8'd5, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_item(FUNC_PIXEL, 8'd5, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'hF800, 32'h07E0, 32'h001F, 32'h0, DEPTH_16, 1'b0);
    queue_item(FUNC_PIXEL, 8'd4, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'hF800, 32'h07E0, 32'h001F, 32'h0, DEPTH_8, 1'b1);
    queue_item(FUNC_WRITE, 8'd6, 8'h11, 8'h22, 8'h33, 1'b0);
    queue_item(FUNC_PIXEL, 8'd200, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(FUNC_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);

    set_format(32'h0, 32'h00FF_FF00, 32'h8000_0000, 32'h0000_0F00, DEPTH_32_ALT, 1'b0);
    queue_item(FUNC_WRITE, 8'd7, 8'hFF, 8'h81, 8'hFF, 1'b0);
    queue_item(FUNC_PIXEL, 8'd7, 8'h00, 8'h00, 8'h00, 1'b0);

    for (int p = 0; p < 12; p++) begin
      if (p == 0) begin
        set_format('1, '1, '1, '1, DEPTH_32, 1'b0);
      end else if (p == 1) begin
        set_format('0, '0, '0, '0, DEPTH_16, 1'b1);
      end else begin
        set_format(pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                   depth_t'($urandom_range(3)), 1'($urandom_range(1)));
      end
      send_idle_pct = (p == 5) ? 0 : 27;
      recv_idle_pct = (p == 5) ? 0 : 27;
      if (p == 7) begin
        queue_item(FUNC_PIXEL, 8'($urandom), 8'h00, 8'h00, 8'h00, 1'b1);
      end
      for (int k = 0; k < 121; k++) begin
        queue_random_item();
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
